[rtl/stl_pkg.sv]
// Shared types, token and error codes, and keyword tables for the source token lexer.
package stl_pkg;

  localparam int unsigned TEXT_LEN_W = 6;
  localparam int unsigned NUM_KW     = 7;

  localparam logic [4:0] KIND_NUMBER    = 5'd0;
  localparam logic [4:0] KIND_IDENT     = 5'd1;
  localparam logic [4:0] KIND_STRING    = 5'd2;
  localparam logic [4:0] KIND_KW_BASE   = 5'd3;
  localparam logic [4:0] KIND_PLUS      = 5'd10;
  localparam logic [4:0] KIND_INCR      = 5'd11;
  localparam logic [4:0] KIND_MINUS     = 5'd12;
  localparam logic [4:0] KIND_DECR      = 5'd13;
  localparam logic [4:0] KIND_ASSIGN    = 5'd14;
  localparam logic [4:0] KIND_EQ_EQ     = 5'd15;
  localparam logic [4:0] KIND_EQ_PLUS   = 5'd16;
  localparam logic [4:0] KIND_EQ_MINUS  = 5'd17;
  localparam logic [4:0] KIND_EQ_STAR   = 5'd18;
  localparam logic [4:0] KIND_EQ_SLASH  = 5'd19;
  localparam logic [4:0] KIND_EQ_AND    = 5'd20;
  localparam logic [4:0] KIND_EQ_OR     = 5'd21;
  localparam logic [4:0] KIND_EQ_SHL    = 5'd22;
  localparam logic [4:0] KIND_EQ_SHR    = 5'd23;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN    = 3'd1;
  localparam logic [2:0] ERR_SHIFT      = 3'd2;
  localparam logic [2:0] ERR_UNTERM     = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd4;

  localparam logic [63:0] SAT_MAG = 64'h8000_0000_0000_0000;
  // Largest magnitude that can take one more decimal digit without passing 2^63.
  localparam logic [63:0] ACC_LIM = 64'd922337203685477580;

  localparam logic [7:0] KW_TEXT [NUM_KW][6] = '{
    '{"r", "e", "t", "u", "r", "n"},
    '{"a", "u", "t", "o", 8'h00, 8'h00},
    '{"e", "x", "t", "r", "n", 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"b", "r", "e", "a", "k", 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd4, 3'd5, 3'd2, 3'd4, 3'd5, 3'd5};

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_IDENT, M_STR, M_PLUS, M_MINUS, M_EQ, M_EQLT, M_EQGT
  } lex_mode_e;

  typedef enum logic [1:0] {
    BS_IDLE, BS_READ, BS_EMIT
  } back_state_e;

  // One command for the back end: a single result, or a text run out of the store.
  typedef struct packed {
    logic                  is_run;
    logic [4:0]            kind;
    logic [TEXT_LEN_W-1:0] len;
    logic [63:0]           num;
    logic [2:0]            err;
  } cmd_t;

  typedef struct packed {
    logic                  we;
    logic [TEXT_LEN_W-1:0] addr;
    logic [7:0]            data;
  } text_wr_t;

endpackage

[rtl/stl_queue.sv]
// Two-entry command queue between the lexer front end and the result back end.
module stl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stl_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output stl_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  stl_pkg::cmd_t entry_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = entry_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = wp_q ^ do_push;
    rp_d  = rp_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wp_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/stl_front.sv]
// Lexer front end: takes source bytes, tracks the lexing mode and issues result commands.
module stl_front #(
  parameter int unsigned MAX_TEXT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_byte_i,
  input  logic              end_of_input_i,
  input  logic              fifo_full_i,
  input  logic              run_done_i,
  output logic              push_o,
  output stl_pkg::cmd_t     push_cmd_o,
  output stl_pkg::text_wr_t wr_o
);

  localparam logic [7:0] ChZero  = "0";
  localparam logic [7:0] ChNine  = "9";
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChPlus  = "+";
  localparam logic [7:0] ChMinus = "-";
  localparam logic [7:0] ChEq    = "=";
  localparam logic [7:0] ChLt    = "<";
  localparam logic [7:0] ChGt    = ">";
  localparam logic [7:0] ChStar  = "*";
  localparam logic [7:0] ChSlash = "/";
  localparam logic [7:0] ChAnd   = "&";
  localparam logic [7:0] ChOr    = "|";
  localparam logic [7:0] ChUnder = "_";
  localparam logic [7:0] ChDollar = "$";
  localparam logic [7:0] ChSpace = " ";
  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [stl_pkg::TEXT_LEN_W-1:0] MaxLen = stl_pkg::TEXT_LEN_W'(MAX_TEXT);

  stl_pkg::lex_mode_e mode_q, mode_d;
  logic [stl_pkg::TEXT_LEN_W-1:0] len_q, len_d;
  logic [63:0]                    acc_q, acc_d;
  logic                           neg_q, neg_d;
  logic                           err_q, err_d;
  logic [stl_pkg::NUM_KW-1:0]     kwm_q, kwm_d;
  logic                           pend_q;
  stl_pkg::cmd_t                  pend_cmd_q;
  logic                           run_out_q;

  stl_pkg::cmd_t   cmds [2];
  logic [1:0]      ncmd;
  stl_pkg::text_wr_t wr_d;
  logic            take;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [3:0] d);
    logic [63:0] r;
    if ((acc > stl_pkg::ACC_LIM) || ((acc == stl_pkg::ACC_LIM) && (d == 4'd9))) begin
      r = stl_pkg::SAT_MAG;
    end else begin
      r = (acc << 3) + (acc << 1) + {60'd0, d};
    end
    return r;
  endfunction

  function automatic logic [63:0] num_value(input logic [63:0] acc, input logic neg);
    logic [63:0] r;
    if (neg) begin
      r = (acc >= stl_pkg::SAT_MAG) ? stl_pkg::SAT_MAG : (~acc + 64'd1);
    end else begin
      r = (acc >= stl_pkg::SAT_MAG) ? (stl_pkg::SAT_MAG - 64'd1) : acc;
    end
    return r;
  endfunction

  function automatic stl_pkg::cmd_t single(input logic [4:0] kind, input logic [63:0] num,
                                           input logic [2:0] err);
    stl_pkg::cmd_t r;
    r        = '0;
    r.kind   = kind;
    r.num    = num;
    r.err    = err;
    return r;
  endfunction

  // Keeps the keywords that still agree with the text stored so far.
  function automatic logic [stl_pkg::NUM_KW-1:0] kw_step(
      input logic [stl_pkg::NUM_KW-1:0] kwm, input logic [stl_pkg::TEXT_LEN_W-1:0] len,
      input logic [7:0] c);
    logic [stl_pkg::NUM_KW-1:0] r;
    for (int k = 0; k < stl_pkg::NUM_KW; k++) begin
      r[k] = kwm[k] && (len < {3'd0, stl_pkg::KW_LEN[k]}) &&
             (stl_pkg::KW_TEXT[k][len[2:0]] == c);
    end
    return r;
  endfunction

  assign in_stall_o = pend_q || run_out_q || fifo_full_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    logic       do_start;
    logic       want_store;
    logic       kw_hit;
    logic [4:0] kw_kind;
    stl_pkg::cmd_t run_cmd;
    mode_d     = mode_q;
    len_d      = len_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    err_d      = err_q;
    kwm_d      = kwm_q;
    cmds[0]    = '0;
    cmds[1]    = '0;
    ncmd       = 2'd0;
    wr_d       = '0;
    do_start   = 1'b0;
    want_store = 1'b0;
    kw_hit     = 1'b0;
    kw_kind    = stl_pkg::KIND_KW_BASE;
    run_cmd    = '0;

    if (take && !err_q) begin
      unique case (mode_q)
        stl_pkg::M_NUM: begin
          if (is_digit(char_byte_i)) begin
            acc_d = add_digit(acc_q, char_byte_i[3:0]);
          end else begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_NUMBER, num_value(acc_q, neg_q),
                                   stl_pkg::ERR_NONE);
            ncmd = ncmd + 2'd1;
            do_start = 1'b1;
          end
        end
        stl_pkg::M_IDENT: begin
          if (is_letter(char_byte_i) || is_digit(char_byte_i) ||
              (char_byte_i == ChUnder) || (char_byte_i == ChDollar)) begin
            want_store = 1'b1;
          end else begin
            for (int k = stl_pkg::NUM_KW - 1; k >= 0; k--) begin
              if (kwm_q[k] && (len_q == {3'd0, stl_pkg::KW_LEN[k]})) begin
                kw_hit  = 1'b1;
                kw_kind = stl_pkg::KIND_KW_BASE + 5'(k);
              end
            end
            if (kw_hit) begin
              cmds[ncmd[0]] = single(kw_kind, 64'd0, stl_pkg::ERR_NONE);
            end else begin
              run_cmd        = '0;
              run_cmd.is_run = 1'b1;
              run_cmd.kind   = stl_pkg::KIND_IDENT;
              run_cmd.len    = len_q;
              cmds[ncmd[0]]  = run_cmd;
            end
            ncmd = ncmd + 2'd1;
            do_start = 1'b1;
          end
        end
        stl_pkg::M_STR: begin
          if (char_byte_i == ChQuote) begin
            if (len_q == '0) begin
              cmds[ncmd[0]] = single(stl_pkg::KIND_STRING, 64'd0, stl_pkg::ERR_NONE);
            end else begin
              run_cmd        = '0;
              run_cmd.is_run = 1'b1;
              run_cmd.kind   = stl_pkg::KIND_STRING;
              run_cmd.len    = len_q;
              cmds[ncmd[0]]  = run_cmd;
            end
            ncmd   = ncmd + 2'd1;
            mode_d = stl_pkg::M_IDLE;
          end else begin
            want_store = 1'b1;
          end
        end
        stl_pkg::M_PLUS: begin
          if (char_byte_i == ChPlus) begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_INCR, 64'd0, stl_pkg::ERR_NONE);
            mode_d = stl_pkg::M_IDLE;
          end else begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_PLUS, 64'd0, stl_pkg::ERR_NONE);
            do_start = 1'b1;
          end
          ncmd = ncmd + 2'd1;
        end
        stl_pkg::M_MINUS: begin
          if (char_byte_i == ChMinus) begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_DECR, 64'd0, stl_pkg::ERR_NONE);
            ncmd   = ncmd + 2'd1;
            mode_d = stl_pkg::M_IDLE;
          end else if (is_digit(char_byte_i)) begin
            mode_d = stl_pkg::M_NUM;
            neg_d  = 1'b1;
            acc_d  = add_digit(64'd0, char_byte_i[3:0]);
          end else begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_MINUS, 64'd0, stl_pkg::ERR_NONE);
            ncmd     = ncmd + 2'd1;
            do_start = 1'b1;
          end
        end
        stl_pkg::M_EQ: begin
          mode_d = stl_pkg::M_IDLE;
          unique case (char_byte_i)
            ChLt:    mode_d = stl_pkg::M_EQLT;
            ChGt:    mode_d = stl_pkg::M_EQGT;
            ChEq:    cmds[ncmd[0]] = single(stl_pkg::KIND_EQ_EQ, 64'd0, stl_pkg::ERR_NONE);
            ChPlus:  cmds[ncmd[0]] = single(stl_pkg::KIND_EQ_PLUS, 64'd0, stl_pkg::ERR_NONE);
            ChMinus: cmds[ncmd[0]] = single(stl_pkg::KIND_EQ_MINUS, 64'd0, stl_pkg::ERR_NONE);
            ChStar:  cmds[ncmd[0]] = single(stl_pkg::KIND_EQ_STAR, 64'd0, stl_pkg::ERR_NONE);
            ChSlash: cmds[ncmd[0]] = single(stl_pkg::KIND_EQ_SLASH, 64'd0, stl_pkg::ERR_NONE);
            ChAnd:   cmds[ncmd[0]] = single(stl_pkg::KIND_EQ_AND, 64'd0, stl_pkg::ERR_NONE);
            ChOr:    cmds[ncmd[0]] = single(stl_pkg::KIND_EQ_OR, 64'd0, stl_pkg::ERR_NONE);
            default: begin
              cmds[ncmd[0]] = single(stl_pkg::KIND_ASSIGN, 64'd0, stl_pkg::ERR_NONE);
              do_start = 1'b1;
            end
          endcase
          if ((char_byte_i != ChLt) && (char_byte_i != ChGt)) begin
            ncmd = ncmd + 2'd1;
          end
        end
        stl_pkg::M_EQLT, stl_pkg::M_EQGT: begin
          if (((mode_q == stl_pkg::M_EQLT) && (char_byte_i == ChLt)) ||
              ((mode_q == stl_pkg::M_EQGT) && (char_byte_i == ChGt))) begin
            cmds[ncmd[0]] = single((mode_q == stl_pkg::M_EQLT) ? stl_pkg::KIND_EQ_SHL
                                                               : stl_pkg::KIND_EQ_SHR,
                                   64'd0, stl_pkg::ERR_NONE);
            mode_d = stl_pkg::M_IDLE;
          end else begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_NUMBER, 64'd0, stl_pkg::ERR_SHIFT);
            err_d = 1'b1;
          end
          ncmd = ncmd + 2'd1;
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        mode_d = stl_pkg::M_IDLE;
        if (is_digit(char_byte_i)) begin
          mode_d = stl_pkg::M_NUM;
          neg_d  = 1'b0;
          acc_d  = add_digit(64'd0, char_byte_i[3:0]);
        end else if (is_letter(char_byte_i)) begin
          mode_d     = stl_pkg::M_IDENT;
          len_d      = '0;
          kwm_d      = '1;
          want_store = 1'b1;
        end else if (char_byte_i == ChQuote) begin
          mode_d = stl_pkg::M_STR;
          len_d  = '0;
        end else if (char_byte_i == ChPlus) begin
          mode_d = stl_pkg::M_PLUS;
        end else if (char_byte_i == ChMinus) begin
          mode_d = stl_pkg::M_MINUS;
        end else if (char_byte_i == ChEq) begin
          mode_d = stl_pkg::M_EQ;
        end else if ((char_byte_i != ChSpace) && (char_byte_i != ChNl)) begin
          cmds[ncmd[0]] = single(stl_pkg::KIND_NUMBER, 64'd0, stl_pkg::ERR_UNKNOWN);
          ncmd  = ncmd + 2'd1;
          err_d = 1'b1;
        end
      end

      if (want_store) begin
        if (len_d >= MaxLen) begin
          cmds[ncmd[0]] = single(stl_pkg::KIND_NUMBER, 64'd0, stl_pkg::ERR_TOO_LONG);
          ncmd  = ncmd + 2'd1;
          err_d = 1'b1;
        end else begin
          wr_d.we   = 1'b1;
          wr_d.addr = len_d;
          wr_d.data = char_byte_i;
          kwm_d     = kw_step(kwm_d, len_d, char_byte_i);
          len_d     = len_d + 1'b1;
        end
      end

      // End of input flushes whatever token is still open.
      if (end_of_input_i && !err_d) begin
        unique case (mode_d)
          stl_pkg::M_NUM: begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_NUMBER, num_value(acc_d, neg_d),
                                   stl_pkg::ERR_NONE);
            ncmd = ncmd + 2'd1;
          end
          stl_pkg::M_IDENT: begin
            for (int k = stl_pkg::NUM_KW - 1; k >= 0; k--) begin
              if (kwm_d[k] && (len_d == {3'd0, stl_pkg::KW_LEN[k]})) begin
                kw_hit  = 1'b1;
                kw_kind = stl_pkg::KIND_KW_BASE + 5'(k);
              end
            end
            if (kw_hit) begin
              cmds[ncmd[0]] = single(kw_kind, 64'd0, stl_pkg::ERR_NONE);
            end else begin
              run_cmd        = '0;
              run_cmd.is_run = 1'b1;
              run_cmd.kind   = stl_pkg::KIND_IDENT;
              run_cmd.len    = len_d;
              cmds[ncmd[0]]  = run_cmd;
            end
            ncmd = ncmd + 2'd1;
          end
          stl_pkg::M_STR: begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_NUMBER, 64'd0, stl_pkg::ERR_UNTERM);
            ncmd = ncmd + 2'd1;
          end
          stl_pkg::M_PLUS: begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_PLUS, 64'd0, stl_pkg::ERR_NONE);
            ncmd = ncmd + 2'd1;
          end
          stl_pkg::M_MINUS: begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_MINUS, 64'd0, stl_pkg::ERR_NONE);
            ncmd = ncmd + 2'd1;
          end
          stl_pkg::M_EQ: begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_ASSIGN, 64'd0, stl_pkg::ERR_NONE);
            ncmd = ncmd + 2'd1;
          end
          stl_pkg::M_EQLT, stl_pkg::M_EQGT: begin
            cmds[ncmd[0]] = single(stl_pkg::KIND_NUMBER, 64'd0, stl_pkg::ERR_SHIFT);
            ncmd = ncmd + 2'd1;
          end
          default: ;
        endcase
      end
    end

    if (take && end_of_input_i) begin
      mode_d = stl_pkg::M_IDLE;
      len_d  = '0;
      acc_d  = '0;
      neg_d  = 1'b0;
      err_d  = 1'b0;
    end
  end

  // Command output: the first command of a byte goes straight out, a second one waits.
  always_comb begin
    push_o     = (take && (ncmd != 2'd0)) || (pend_q && !fifo_full_i);
    push_cmd_o = pend_q ? pend_cmd_q : cmds[0];
    wr_o       = wr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= stl_pkg::M_IDLE;
      len_q     <= '0;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      err_q     <= 1'b0;
      kwm_q     <= '0;
      pend_q    <= 1'b0;
      run_out_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      err_q  <= err_d;
      kwm_q  <= kwm_d;
      if (take && (ncmd == 2'd2)) begin
        pend_q <= 1'b1;
      end else if (pend_q && !fifo_full_i) begin
        pend_q <= 1'b0;
      end
      // The text store stays frozen while a run is waiting or being sent.
      if (take && (cmds[0].is_run || cmds[1].is_run)) begin
        run_out_q <= 1'b1;
      end else if (run_done_i) begin
        run_out_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && (ncmd == 2'd2)) begin
      pend_cmd_q <= cmds[1];
    end
  end

endmodule

[rtl/stl_back.sv]
// Result back end: holds the text store and turns commands into result transfers.
module stl_back #(
  parameter int unsigned MAX_TEXT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fifo_empty_i,
  input  stl_pkg::cmd_t     fifo_cmd_i,
  output logic              pop_o,
  input  stl_pkg::text_wr_t wr_i,
  output logic              run_done_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [4:0]        token_kind_o,
  output logic [7:0]        text_char_o,
  output logic signed [63:0] number_value_o,
  output logic [2:0]        error_code_o,
  output logic              last_of_run_o
);

  localparam int unsigned AW = $clog2(MAX_TEXT);

  logic [7:0] mem_q [MAX_TEXT];
  logic [7:0] rd_q;

  stl_pkg::back_state_e state_q, state_d;
  logic [4:0]                     kind_q;
  logic [stl_pkg::TEXT_LEN_W-1:0] len_q;
  logic [stl_pkg::TEXT_LEN_W-1:0] idx_q;
  logic                           out_valid_q;
  logic [4:0]                     out_kind_q;
  logic [7:0]                     out_char_q;
  logic [63:0]                    out_num_q;
  logic [2:0]                     out_err_q;
  logic                           out_last_q;

  logic out_free;
  logic load_single;
  logic load_char;
  logic char_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign char_last = ((idx_q + 1'b1) == len_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stl_pkg::BS_IDLE: begin
        if (!fifo_empty_i && fifo_cmd_i.is_run) begin
          state_d = stl_pkg::BS_READ;
        end
      end
      stl_pkg::BS_READ: state_d = stl_pkg::BS_EMIT;
      stl_pkg::BS_EMIT: begin
        if (out_free) begin
          state_d = char_last ? stl_pkg::BS_IDLE : stl_pkg::BS_READ;
        end
      end
      default: state_d = stl_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == stl_pkg::BS_IDLE) && !fifo_empty_i &&
                  (fifo_cmd_i.is_run || out_free);
    load_single = (state_q == stl_pkg::BS_IDLE) && !fifo_empty_i &&
                  !fifo_cmd_i.is_run && out_free;
    load_char   = (state_q == stl_pkg::BS_EMIT) && out_free;
    run_done_o  = load_char && char_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stl_pkg::BS_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o && fifo_cmd_i.is_run) begin
        idx_q <= '0;
      end else if (load_char && !char_last) begin
        idx_q <= idx_q + 1'b1;
      end
      if (load_single || load_char) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && fifo_cmd_i.is_run) begin
      kind_q <= fifo_cmd_i.kind;
      len_q  <= fifo_cmd_i.len;
    end
    if (load_single) begin
      out_kind_q <= fifo_cmd_i.kind;
      out_char_q <= 8'd0;
      out_num_q  <= fifo_cmd_i.num;
      out_err_q  <= fifo_cmd_i.err;
      out_last_q <= 1'b1;
    end else if (load_char) begin
      out_kind_q <= kind_q;
      out_char_q <= rd_q;
      out_num_q  <= 64'd0;
      out_err_q  <= stl_pkg::ERR_NONE;
      out_last_q <= char_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = out_kind_q;
  assign text_char_o    = out_char_q;
  assign number_value_o = out_num_q;
  assign error_code_o   = out_err_q;
  assign last_of_run_o  = out_last_q;

endmodule

[rtl/source_token_lexer.sv]
// Top level of the source token lexer: front end, command queue and back end.
// A single result is registered in the command queue, then in the output register. A text
// run leaves the queue and each character goes through BS_READ and BS_EMIT to the output.
// Input takes one byte per cycle while not stalled; it stalls on a full queue, while the
// second result of a byte waits, and for a text run until its last character is loaded.
// Reset is asynchronous, active low: lexer idle, queue and output empty, text store kept.
module source_token_lexer #(
  parameter int unsigned MAX_TEXT = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_byte_i,
  input  logic               end_of_input_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         token_kind_o,
  output logic [7:0]         text_char_o,
  output logic signed [63:0] number_value_o,
  output logic [2:0]         error_code_o,
  output logic               last_of_run_o
);

  logic              push;
  stl_pkg::cmd_t     push_cmd;
  logic              pop;
  stl_pkg::cmd_t     head;
  logic              empty;
  logic              full;
  logic              run_done;
  stl_pkg::text_wr_t wr;

  stl_front #(.MAX_TEXT(MAX_TEXT)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_byte_i    (char_byte_i),
    .end_of_input_i (end_of_input_i),
    .fifo_full_i    (full),
    .run_done_i     (run_done),
    .push_o         (push),
    .push_cmd_o     (push_cmd),
    .wr_o           (wr)
  );

  stl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  stl_back #(.MAX_TEXT(MAX_TEXT)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (empty),
    .fifo_cmd_i     (head),
    .pop_o          (pop),
    .wr_i           (wr),
    .run_done_o     (run_done),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .text_char_o    (text_char_o),
    .number_value_o (number_value_o),
    .error_code_o   (error_code_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

[rtl/stl_checker.sv]
// Port-level checks for the source token lexer, bound to the top level.
module stl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [4:0]         token_kind_o,
  input logic [7:0]         text_char_o,
  input logic signed [63:0] number_value_o,
  input logic [2:0]         error_code_o,
  input logic               last_of_run_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(token_kind_o) && $stable(text_char_o))
    else $error("stalled result changed");

  // Error results carry no token and close their run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != stl_pkg::ERR_NONE) |->
      (token_kind_o == stl_pkg::KIND_NUMBER) && last_of_run_o && (number_value_o == 64'sd0))
    else $error("malformed error result");

  // Keywords and operators are single transfers without text or value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o > stl_pkg::KIND_STRING) |->
      last_of_run_o && (text_char_o == 8'd0) && (number_value_o == 64'sd0))
    else $error("malformed operator or keyword result");

  // A result that is not the end of a run is text of an identifier or string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |->
      ((token_kind_o == stl_pkg::KIND_IDENT) || (token_kind_o == stl_pkg::KIND_STRING)) &&
      (error_code_o == stl_pkg::ERR_NONE))
    else $error("open run on a non-text token");

endmodule

bind source_token_lexer stl_checker u_stl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .token_kind_o   (token_kind_o),
  .text_char_o    (text_char_o),
  .number_value_o (number_value_o),
  .error_code_o   (error_code_o),
  .last_of_run_o  (last_of_run_o)
);

[test/tb.sv]
// Testbench for the source token lexer: directed token cases, then random source text.
module tb;

  localparam int unsigned MAX_TEXT = 32;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  ch;
    logic [63:0] num;
    logic [2:0]  err;
    logic        last;
  } token_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_byte_i = 8'd0;
  logic               end_of_input_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [4:0]         token_kind_o;
  logic [7:0]         text_char_o;
  logic signed [63:0] number_value_o;
  logic [2:0]         error_code_o;
  logic               last_of_run_o;

  source_token_lexer #(.MAX_TEXT(MAX_TEXT)) dut (.*);

  always #1 clk_i = ~clk_i;

  // Predictor state.
  stl_pkg::lex_mode_e p_mode;
  logic [7:0]  p_text [MAX_TEXT];
  int          p_len;
  logic [63:0] p_acc;
  logic        p_neg;
  logic        p_err;

  token_t expected_tokens [$];
  int     fail_count = 0;
  bit     hold_off = 1'b0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void push_token(input logic [4:0] k, input logic [7:0] c,
                                     input logic [63:0] n, input logic [2:0] e,
                                     input logic l);
    token_t t;
    t = '{k, c, n, e, l};
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function automatic void push_op(input logic [4:0] k);
    push_token(k, 8'd0, 64'd0, stl_pkg::ERR_NONE, 1'b1);
  endfunction

  function automatic void lex_error(input logic [2:0] code);
    push_token(stl_pkg::KIND_NUMBER, 8'd0, 64'd0, code, 1'b1);
    p_err = 1'b1;
  endfunction

  function automatic void lex_clear();
    p_mode = stl_pkg::M_IDLE;
    p_len = 0;
    p_acc = 64'd0;
    p_neg = 1'b0;
    p_err = 1'b0;
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - "0");
    if (p_acc > (stl_pkg::SAT_MAG - d) / 10) p_acc = stl_pkg::SAT_MAG;
    else p_acc = p_acc * 10 + d;
  endfunction

  function automatic void flush_number();
    logic [63:0] v;
    if (p_neg) v = (p_acc >= stl_pkg::SAT_MAG) ? stl_pkg::SAT_MAG : -p_acc;
    else v = (p_acc >= stl_pkg::SAT_MAG) ? stl_pkg::SAT_MAG - 1 : p_acc;
    push_token(stl_pkg::KIND_NUMBER, 8'd0, v, stl_pkg::ERR_NONE, 1'b1);
  endfunction

  function automatic void flush_text(input logic [4:0] k);
    if (p_len == 0) begin
      push_token(k, 8'd0, 64'd0, stl_pkg::ERR_NONE, 1'b1);
      return;
    end
    for (int i = 0; i < p_len; i++)
      push_token(k, p_text[i], 64'd0, stl_pkg::ERR_NONE, i + 1 == p_len);
  endfunction

  function automatic void flush_ident();
    bit hit;
    for (int k = 0; k < stl_pkg::NUM_KW; k++) begin
      hit = (p_len == stl_pkg::KW_LEN[k]);
      for (int i = 0; i < stl_pkg::KW_LEN[k] && hit; i++)
        if (p_text[i] != stl_pkg::KW_TEXT[k][i]) hit = 0;
      if (hit) begin
        push_op(stl_pkg::KIND_KW_BASE + 5'(k));
        return;
      end
    end
    flush_text(stl_pkg::KIND_IDENT);
  endfunction

  function automatic void store_char(input logic [7:0] c);
    if (p_len >= MAX_TEXT) begin
      lex_error(stl_pkg::ERR_TOO_LONG);
      return;
    end
    p_text[p_len] = c;
    p_len++;
  endfunction

  function automatic void start_token(input logic [7:0] c);
    p_mode = stl_pkg::M_IDLE;
    if (is_digit(c)) begin
      p_mode = stl_pkg::M_NUM; p_neg = 0; p_acc = 0; add_digit(c);
    end else if (is_letter(c)) begin
      p_mode = stl_pkg::M_IDENT; p_len = 0; store_char(c);
    end else if (c == "\"") begin
      p_mode = stl_pkg::M_STR; p_len = 0;
    end else if (c == "+") p_mode = stl_pkg::M_PLUS;
    else if (c == "-") p_mode = stl_pkg::M_MINUS;
    else if (c == "=") p_mode = stl_pkg::M_EQ;
    else if (c != " " && c != 8'h0a) lex_error(stl_pkg::ERR_UNKNOWN);
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic eoi);
    if (p_err) begin
      if (eoi) lex_clear();
      return;
    end
    case (p_mode)
      stl_pkg::M_NUM:
        if (is_digit(c)) add_digit(c);
        else begin flush_number(); start_token(c); end
      stl_pkg::M_IDENT:
        if (is_letter(c) || is_digit(c) || c == "_" || c == "$") store_char(c);
        else begin flush_ident(); start_token(c); end
      stl_pkg::M_STR:
        if (c == "\"") begin flush_text(stl_pkg::KIND_STRING); p_mode = stl_pkg::M_IDLE; end
        else store_char(c);
      stl_pkg::M_PLUS:
        if (c == "+") begin push_op(stl_pkg::KIND_INCR); p_mode = stl_pkg::M_IDLE; end
        else begin push_op(stl_pkg::KIND_PLUS); start_token(c); end
      stl_pkg::M_MINUS:
        if (c == "-") begin push_op(stl_pkg::KIND_DECR); p_mode = stl_pkg::M_IDLE; end
        else if (is_digit(c)) begin
          p_mode = stl_pkg::M_NUM; p_neg = 1; p_acc = 0; add_digit(c);
        end else begin push_op(stl_pkg::KIND_MINUS); start_token(c); end
      stl_pkg::M_EQ: begin
        logic [4:0] k;
        bit ok;
        ok = 1;
        case (c)
          "=": k = stl_pkg::KIND_EQ_EQ;
          "+": k = stl_pkg::KIND_EQ_PLUS;
          "-": k = stl_pkg::KIND_EQ_MINUS;
          "*": k = stl_pkg::KIND_EQ_STAR;
          "/": k = stl_pkg::KIND_EQ_SLASH;
          "&": k = stl_pkg::KIND_EQ_AND;
          "|": k = stl_pkg::KIND_EQ_OR;
          default: begin k = stl_pkg::KIND_ASSIGN; ok = 0; end
        endcase
        if (c == "<") p_mode = stl_pkg::M_EQLT;
        else if (c == ">") p_mode = stl_pkg::M_EQGT;
        else if (ok) begin push_op(k); p_mode = stl_pkg::M_IDLE; end
        else begin push_op(stl_pkg::KIND_ASSIGN); start_token(c); end
      end
      stl_pkg::M_EQLT:
        if (c == "<") begin push_op(stl_pkg::KIND_EQ_SHL); p_mode = stl_pkg::M_IDLE; end
        else lex_error(stl_pkg::ERR_SHIFT);
      stl_pkg::M_EQGT:
        if (c == ">") begin push_op(stl_pkg::KIND_EQ_SHR); p_mode = stl_pkg::M_IDLE; end
        else lex_error(stl_pkg::ERR_SHIFT);
      default: start_token(c);
    endcase
    if (p_err) begin
      if (eoi) lex_clear();
      return;
    end
    if (eoi) begin
      case (p_mode)
        stl_pkg::M_NUM: flush_number();
        stl_pkg::M_IDENT: flush_ident();
        stl_pkg::M_STR: lex_error(stl_pkg::ERR_UNTERM);
        stl_pkg::M_PLUS: push_op(stl_pkg::KIND_PLUS);
        stl_pkg::M_MINUS: push_op(stl_pkg::KIND_MINUS);
        stl_pkg::M_EQ: push_op(stl_pkg::KIND_ASSIGN);
        stl_pkg::M_EQLT, stl_pkg::M_EQGT: lex_error(stl_pkg::ERR_SHIFT);
        default: ;
      endcase
      lex_clear();
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid stays high between back-to-back bytes and drops only for a gap.
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_byte_i <= c;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(c, eoi);
  endtask

  task automatic send_text(input string s, input bit eoi_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eoi_last && i == s.len() - 1);
  endtask

  task automatic test_operators();
    send_text("++ -- == =+ =- =* =/ =& =| =<< =>> +a -b =c", 1);
    send_text("+", 1);
    send_text("-", 1);
    send_text("=", 1);
  endtask

  task automatic test_numbers_and_keywords();
    send_text("9223372036854775807 9223372036854775808 -9223372036854775809", 1);
    send_text("return auto extrn if else while break iff \"\" \"a b\"", 1);
  endtask

  task automatic test_errors();
    send_text("_", 1);
    send_text("$", 1);
    send_text("=<a", 1);
    send_text("=>", 1);
    send_text("\"open", 1);
    send_text("abcdefghijklmnopqrstuvwxyzABCDEFG", 1);
    send_byte(8'hff, 1);
  endtask

  task automatic test_back_pressure();
    hold_off = 1'b1;
    send_text("abc \"qr\" 12 + - = ", 1);
    hold_off = 1'b0;
  endtask

  task automatic test_random();
    string frags [16];
    int r, n;
    frags = '{"if", "while", "x", "a1$_", "\"s t\"", "42", "-13", "++", "--", "=+",
              "=<<", "=>>", "==", "=", "+", "-"};
    for (int s = 0; s < 3; s++) begin
      n = $urandom_range(1, 2);
      for (int f = 0; f < n; f++) begin
        r = $urandom_range(0, 99);
        if (r < 80) send_text(frags[$urandom_range(0, 15)], 0);
        else if (r < 90) send_byte(8'($urandom_range(0, 255)), 0);
        else send_text($sformatf("%0d", $urandom), 0);
        send_byte($urandom_range(0, 3) == 0 ? 8'h0a : " ", 0);
      end
      send_byte(8'($urandom_range(0, 255)), 1);
    end
  endtask

  // Receiver: random stall, with a long hold-off when requested.
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        wait (!hold_off);
      end else begin
        gap = gap_len();
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Checker of each result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        report("result with none expected");
      end else begin
        token_t e;
        e = expected_tokens.pop_front();
        if (token_kind_o !== e.kind)
          report($sformatf("kind %0d, expected %0d", token_kind_o, e.kind));
        if (text_char_o !== e.ch)
          report($sformatf("char %0h, expected %0h", text_char_o, e.ch));
        if (number_value_o !== e.num)
          report($sformatf("number %0d, expected %0d", number_value_o, $signed(e.num)));
        if (error_code_o !== e.err)
          report($sformatf("error %0d, expected %0d", error_code_o, e.err));
        if (last_of_run_o !== e.last)
          report($sformatf("last %0b, expected %0b", last_of_run_o, e.last));
      end
    end
  end

  initial begin
    lex_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_operators();
    test_numbers_and_keywords();
    test_errors();
    test_back_pressure();
    test_random();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
